// ===== rtl/assert_macros.svh =====
// Assertion macros for the linear-probe key-value table.
// Used by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPKV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define LPKV_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define LPKV_ASSERT(label, clk, rst_n, prop)
`define LPKV_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/lpkv_pkg.sv =====
// Shared types and constants for the linear-probe key-value table.
// No dependencies.
package lpkv_pkg;

    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int MAX_CHARS   = 8;
    localparam int SLOT_FLD_W  = 4;
    localparam int SUM_W       = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_item;

endpackage

// ===== rtl/lpkv_front.sv =====
// Front end: takes a request, trims the key and works out its hash slot.
// Depends on lpkv_pkg.
module lpkv_front #(
    parameter int SLOTS     = 13,
    parameter int KEY_CHARS = 8,
    localparam int IDX_W    = $clog2(SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lpkv_pkg::t_item      i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lpkv_pkg::t_item      o_out_item,
    output logic [IDX_W-1:0]     o_out_hash
);
    import lpkv_pkg::*;

    // floor(x / SLOTS) == (x * RECIP) >> RECIP_SH for every x below 2**SUM_W
    localparam int RECIP_SH = SUM_W + IDX_W;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int QUO_W    = PROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**RECIP_SH + SLOTS - 1) / SLOTS);

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_NORM = 3'd1;
    localparam logic [2:0] FS_QUO  = 3'd2;
    localparam logic [2:0] FS_REM  = 3'd3;
    localparam logic [2:0] FS_PUSH = 3'd4;

    logic [2:0]             r_state, n_state;
    t_item                  r_item, n_item;
    logic [SUM_W-1:0]       r_rem, n_rem;
    logic [QUO_W-1:0]       r_quo, n_quo;

    logic [KEY_W-1:0]  w_norm;
    logic [SUM_W-1:0]  w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_qd;

    function automatic logic [KEY_W-1:0] f_normalize(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < MAX_CHARS; i++) begin
            if (i >= KEY_CHARS || k[i*CHAR_W +: CHAR_W] == '0) begin
                live = 1'b0;
            end
            if (live) begin
                r[i*CHAR_W +: CHAR_W] = k[i*CHAR_W +: CHAR_W];
            end
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] f_char_sum(input logic [KEY_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < MAX_CHARS; i++) begin
            s = s + SUM_W'(k[i*CHAR_W +: CHAR_W]);
        end
        return s;
    endfunction

    assign w_norm = f_normalize(r_item.key);
    assign w_sum  = f_char_sum(w_norm);
    assign w_prod = PROD_W'(r_rem) * PROD_W'(RECIP);
    assign w_qd   = SUM_W'(r_quo * SLOTS);

    // hash: quotient by reciprocal multiply, then remainder
    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_rem   = r_rem;
        n_quo   = r_quo;
        unique case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = FS_NORM;
                end
            end
            FS_NORM: begin
                n_item.key = w_norm;
                n_rem      = w_sum;
                n_state    = FS_QUO;
            end
            FS_QUO: begin
                n_quo   = w_prod[PROD_W-1:RECIP_SH];
                n_state = FS_REM;
            end
            FS_REM: begin
                n_rem   = r_rem - w_qd;
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (i_out_ready) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    assign o_in_ready  = (r_state == FS_IDLE);
    assign o_out_valid = (r_state == FS_PUSH);
    assign o_out_item  = r_item;
    assign o_out_hash  = r_rem[IDX_W-1:0];

endmodule

// ===== rtl/lpkv_queue.sv =====
// Short request queue between the front and back ends.
// No dependencies.
module lpkv_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/lpkv_back.sv =====
// Back end: slot store, linear probe for insert, ordered scan for lookups.
// Depends on lpkv_pkg; drives the result register.
module lpkv_back #(
    parameter int SLOTS  = 13,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int SLOT_W = (IDX_W > lpkv_pkg::SLOT_FLD_W) ? IDX_W : lpkv_pkg::SLOT_FLD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  lpkv_pkg::t_item               i_item,
    input  logic [IDX_W-1:0]              i_hash,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lpkv_pkg::STAT_W-1:0]   o_m_status,
    output logic [SLOT_W-1:0]             o_m_slot,
    output logic [lpkv_pkg::VAL_W-1:0]    o_m_value
);
    import lpkv_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    localparam logic [1:0] BS_IDLE  = 2'd0;
    localparam logic [1:0] BS_PROBE = 2'd1;
    localparam logic [1:0] BS_SCAN  = 2'd2;
    localparam logic [1:0] BS_RESP  = 2'd3;

    logic [KEY_W-1:0] r_key_mem [SLOTS];
    logic [VAL_W-1:0] r_val_mem [SLOTS];

    logic [1:0]        r_state, n_state;
    logic [SLOTS-1:0]  r_valid, n_valid;
    t_item             r_item, n_item;
    logic [IDX_W-1:0]  r_p, n_p;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_scan, n_scan;
    logic              r_issue_done, n_issue_done;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]  r_res_slot, n_res_slot;
    logic [VAL_W-1:0]  r_res_value, n_res_value;
    logic              r_m_tvalid;
    logic [STAT_W-1:0] r_m_status;
    logic [SLOT_W-1:0] r_m_slot;
    logic [VAL_W-1:0]  r_m_value;

    logic             w_key_we, w_val_we, w_hit, w_load;
    logic [IDX_W-1:0] w_wr_idx;

    assign w_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_key == r_item.key);
    assign w_load = (r_state == BS_RESP) && (!r_m_tvalid || i_m_tready);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_item       = r_item;
        n_p          = r_p;
        n_cnt        = r_cnt;
        n_scan       = r_scan;
        n_issue_done = r_issue_done;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_value  = r_res_value;
        w_key_we     = 1'b0;
        w_val_we     = 1'b0;
        w_wr_idx     = r_cmp_idx;
        unique case (r_state)
            BS_IDLE: begin
                if (i_valid) begin
                    n_item       = i_item;
                    n_p          = i_hash;
                    n_cnt        = '0;
                    n_scan       = '0;
                    n_issue_done = 1'b0;
                    n_state      = (i_item.op == OP_INSERT) ? BS_PROBE : BS_SCAN;
                end
            end
            BS_PROBE: begin
                w_wr_idx = r_p;
                if (!r_valid[r_p]) begin
                    w_key_we       = 1'b1;
                    w_val_we       = 1'b1;
                    n_valid[r_p]   = 1'b1;
                    n_res_status   = ST_OK;
                    n_res_slot     = r_p;
                    n_res_value    = '0;
                    n_state        = BS_RESP;
                end else if (r_cnt == LAST) begin
                    n_res_status = ST_FULL;
                    n_res_slot   = '0;
                    n_res_value  = '0;
                    n_state      = BS_RESP;
                end else begin
                    n_p   = (r_p == LAST) ? '0 : r_p + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            BS_SCAN: begin
                // read issue runs one slot ahead of the compare
                n_cmp_vld = !r_issue_done;
                n_cmp_idx = r_scan;
                if (!r_issue_done) begin
                    if (r_scan == LAST) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_scan = r_scan + 1'b1;
                    end
                end
                if (w_hit) begin
                    n_res_status = ST_OK;
                    n_res_slot   = r_cmp_idx;
                    n_res_value  = '0;
                    n_state      = BS_RESP;
                    unique case (r_item.op)
                        OP_SEARCH: n_res_value = r_rd_val;
                        OP_MODIFY: w_val_we = 1'b1;
                        OP_DELETE: n_valid[r_cmp_idx] = 1'b0;
                        default: ;
                    endcase
                end else if (r_cmp_vld && r_cmp_idx == LAST) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_slot   = '0;
                    n_res_value  = '0;
                    n_state      = BS_RESP;
                end
            end
            BS_RESP: begin
                if (w_load) begin
                    n_state = BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_valid    <= '0;
            r_cmp_vld  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cmp_vld <= n_cmp_vld;
            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_p          <= n_p;
        r_cnt        <= n_cnt;
        r_scan       <= n_scan;
        r_issue_done <= n_issue_done;
        r_cmp_idx    <= n_cmp_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_value  <= n_res_value;
        if (w_load) begin
            r_m_status <= r_res_status;
            r_m_slot   <= SLOT_W'(r_res_slot);
            r_m_value  <= r_res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_wr_idx] <= r_item.key;
        end
        if (w_val_we) begin
            r_val_mem[w_wr_idx] <= r_item.val;
        end
        r_rd_key <= r_key_mem[r_scan];
        r_rd_val <= r_val_mem[r_scan];
    end

    assign o_ready    = (r_state == BS_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_status = r_m_status;
    assign o_m_slot   = r_m_slot;
    assign o_m_value  = r_m_value;

endmodule

// ===== rtl/linear_probe_key_value_table_top.sv =====
// Top level of the linear-probe key-value table: front end, queue, back end.
// Depends on lpkv_pkg, lpkv_front, lpkv_queue, lpkv_back, assert_macros.svh.
//
//  channel  dir  tuser        tdata (low bit up)
//  s_axis   in   op[1:0]      key_text[63:0], value_text[127:64]
//  m_axis   out  status[1:0]  slot_index[3:0], value_out[67:4], zero pad
//
// Front end: accept, trim and sum the key, reduce the sum mod SLOTS by reciprocal
// multiply in a quotient step and a remainder step, push into a two-entry queue.
// Back end: pop, insert probe over up to SLOTS slots or lookup scan in slot order,
// then load the result; each end takes a new request only when done with the last.
// Reset empties the table at once; a stalled result holds the back end, then the
// queue fills and the input stalls.
`include "assert_macros.svh"
module linear_probe_key_value_table_top #(
    parameter int SLOTS     = 13,
    parameter int KEY_CHARS = 8,
    localparam int IDX_W    = $clog2(SLOTS),
    localparam int SLOT_W   = (IDX_W > lpkv_pkg::SLOT_FLD_W) ? IDX_W : lpkv_pkg::SLOT_FLD_W,
    localparam int OUT_TD_W = ((SLOT_W + lpkv_pkg::VAL_W + 7) / 8) * 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [lpkv_pkg::KEY_W+lpkv_pkg::VAL_W-1:0] s_axis_tdata,  // key_text, value_text
    input  logic [lpkv_pkg::OP_W-1:0]               s_axis_tuser,  // op
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [OUT_TD_W-1:0]                     m_axis_tdata,  // slot_index, value_out
    output logic [lpkv_pkg::STAT_W-1:0]             m_axis_tuser   // status
);
    import lpkv_pkg::*;

    localparam int Q_W = $bits(t_item) + IDX_W;

    t_item             w_in_item;
    logic              w_f_valid, w_f_ready;
    t_item             w_f_item;
    logic [IDX_W-1:0]  w_f_hash;
    logic              w_q_valid, w_q_ready;
    logic [Q_W-1:0]    w_q_data;
    logic [SLOT_W-1:0] w_slot;
    logic [VAL_W-1:0]  w_value;

    assign w_in_item.op  = s_axis_tuser;
    assign w_in_item.key = s_axis_tdata[KEY_W-1:0];
    assign w_in_item.val = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

    lpkv_front #(
        .SLOTS     (SLOTS),
        .KEY_CHARS (KEY_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_item   (w_in_item),
        .o_out_valid (w_f_valid),
        .i_out_ready (w_f_ready),
        .o_out_item  (w_f_item),
        .o_out_hash  (w_f_hash)
    );

    lpkv_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  ({w_f_hash, w_f_item}),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_data)
    );

    lpkv_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_item     (t_item'(w_q_data[$bits(t_item)-1:0])),
        .i_hash     (w_q_data[Q_W-1:$bits(t_item)]),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_status (m_axis_tuser),
        .o_m_slot   (w_slot),
        .o_m_value  (w_value)
    );

    assign m_axis_tdata = OUT_TD_W'({w_value, w_slot});

    `LPKV_ASSERT(a_one_request_at_a_time, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `LPKV_ASSERT(a_slot_in_range, i_clk, i_rst_n, m_axis_tvalid |-> (w_slot < SLOT_W'(SLOTS)))
    `LPKV_ASSERT_NEVER(a_miss_carries_data, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK) && (m_axis_tdata != '0))

endmodule

// ===== dv/lpkv_table_checker.sv =====
// Scoreboard for the key-value table: watches both stream channels, predicts each result.
// Keeps its own copy of the slot store and compares results field by field, in order.
// Depends on lpkv_pkg.
module lpkv_table_checker #(
    parameter int SLOTS     = 13,
    parameter int KEY_CHARS = 8,
    parameter int RSP_W     = 72
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_req_valid,
    input  logic                                       i_req_ready,
    input  logic [lpkv_pkg::KEY_W+lpkv_pkg::VAL_W-1:0] i_req_data,    // key_text, value_text
    input  logic [lpkv_pkg::OP_W-1:0]                  i_req_op,      // op
    input  logic                                       i_rsp_valid,
    input  logic                                       i_rsp_ready,
    input  logic [RSP_W-1:0]                           i_rsp_data,    // slot_index, value_out
    input  logic [lpkv_pkg::STAT_W-1:0]                i_rsp_status,  // status
    output int                                         o_errors,
    output int                                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpkv_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [SLOT_FLD_W-1:0] slot;
        logic [VAL_W-1:0]      value;
    } t_outcome;

    logic             slot_live [SLOTS];
    logic [KEY_W-1:0] slot_key_q [SLOTS];
    logic [VAL_W-1:0] slot_val_q [SLOTS];
    t_outcome         outcomes_due [$];
    int               mismatches = 0;

    // key ends at its first zero byte or after KEY_CHARS characters
    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] kept;
        bit               ended;
        kept  = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (raw[CHAR_W*i +: CHAR_W] == '0) ended = 1'b1;
            if (!ended) kept[CHAR_W*i +: CHAR_W] = raw[CHAR_W*i +: CHAR_W];
        end
        return kept;
    endfunction

    function automatic int home_slot(logic [KEY_W-1:0] key);
        int sum;
        sum = 0;
        for (int i = 0; i < MAX_CHARS; i++) sum += key[CHAR_W*i +: CHAR_W];
        return sum % SLOTS;
    endfunction

    function automatic t_outcome apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] raw_key,
                                               logic [VAL_W-1:0] val);
        t_outcome         res;
        logic [KEY_W-1:0] key;
        int               probe;
        int               hit;
        bit               placed;
        res = '{status: ST_OK, slot: '0, value: '0};
        key = trim_key(raw_key);
        if (op == OP_INSERT) begin
            probe  = home_slot(key);
            placed = 1'b0;
            for (int n = 0; n < SLOTS; n++) begin
                if (!placed) begin
                    if (!slot_live[probe]) begin
                        slot_live[probe]  = 1'b1;
                        slot_key_q[probe] = key;
                        slot_val_q[probe] = val;
                        res.slot          = probe[SLOT_FLD_W-1:0];
                        placed            = 1'b1;
                    end else begin
                        probe = (probe + 1) % SLOTS;
                    end
                end
            end
            if (!placed) res.status = ST_FULL;
        end else begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && slot_live[i] && slot_key_q[i] == key) hit = i;
            if (hit < 0) begin
                res.status = ST_NOT_FOUND;
            end else begin
                res.slot = hit[SLOT_FLD_W-1:0];
                case (op)
                    OP_SEARCH: res.value = slot_val_q[hit];
                    OP_MODIFY: slot_val_q[hit] = val;
                    default:   slot_live[hit] = 1'b0;
                endcase
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome              want;
        logic [SLOT_FLD_W-1:0] got_slot;
        logic [VAL_W-1:0]      got_val;
        got_slot = i_rsp_data[SLOT_FLD_W-1:0];
        got_val  = i_rsp_data[SLOT_FLD_W +: VAL_W];
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
            outcomes_due.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding: status %0d slot %0d value %h",
                             $time, i_rsp_status, got_slot, got_val);
                end else begin
                    want = outcomes_due.pop_front();
                    if (want.status !== i_rsp_status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp_status);
                    end
                    if (want.slot !== got_slot) begin
                        mismatches++;
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want.slot, got_slot);
                    end
                    if (want.value !== got_val) begin
                        mismatches++;
                        $display("%0t: value_out expected %h actual %h",
                                 $time, want.value, got_val);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                outcomes_due.push_back(apply_request(i_req_op, i_req_data[KEY_W-1:0],
                                                     i_req_data[KEY_W +: VAL_W]));
        end
        o_errors  <= mismatches;
        o_pending <= outcomes_due.size();
    end

endmodule

// ===== dv/tb_linear_probe_key_value_table_top.sv =====
// Testbench top for the key-value table: clock, reset, request stimulus and verdict.
// Directed corner cases, then random requests over a small key pool under varied back-pressure.
// Depends on lpkv_pkg, lpkv_table_checker and linear_probe_key_value_table_top.
module tb_linear_probe_key_value_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lpkv_pkg::*;

    localparam int RSP_W         = ((SLOT_FLD_W + VAL_W + 7) / 8) * 8;
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_ITEMS   = 475;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata  = '0;  // key_text, value_text
    logic [OP_W-1:0]        s_tuser  = '0;  // op
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RSP_W-1:0]       m_tdata;        // slot_index, value_out, zero pad
    logic [STAT_W-1:0]      m_tuser;        // status

    int               send_gap_pct  = 0;
    int               rsp_stall_pct = 0;
    int               quiet_cycles  = 0;
    int               mismatch_total;
    int               expected_left;
    logic [KEY_W-1:0] pool_key [POOL_SIZE];
    int               pool_len [POOL_SIZE];

    linear_probe_key_value_table_top uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    lpkv_table_checker #(.RSP_W(RSP_W)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_op     (s_tuser),
        .i_rsp_valid  (m_tvalid),
        .i_rsp_ready  (m_tready),
        .i_rsp_data   (m_tdata),
        .i_rsp_status (m_tuser),
        .o_errors     (mismatch_total),
        .o_pending    (expected_left)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_text(int len);
        logic [KEY_W-1:0] txt;
        txt = '0;
        for (int i = 0; i < len; i++) txt[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(1, 255));
        return txt;
    endfunction

    // pool key, sometimes with junk above the terminating zero byte
    function automatic logic [KEY_W-1:0] pool_pick();
        int               idx;
        logic [KEY_W-1:0] key;
        idx = $urandom_range(POOL_SIZE - 1);
        key = pool_key[idx];
        if (pool_len[idx] < MAX_CHARS - 1 && $urandom_range(3) == 0)
            key |= {$urandom, $urandom} << (CHAR_W * (pool_len[idx] + 1));
        return key;
    endfunction

    task automatic random_request();
        int               roll;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        roll = $urandom_range(99);
        op   = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_SEARCH :
               (roll < 70) ? OP_MODIFY : OP_DELETE;
        key  = ($urandom_range(99) < 12) ? {$urandom, $urandom} : pool_pick();
        roll = $urandom_range(9);
        val  = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
        send_request(op, key, val);
    endtask

    initial begin
        pool_key[0] = '0;
        pool_len[0] = 0;
        for (int i = 1; i < POOL_SIZE; i++) begin
            pool_len[i] = $urandom_range(1, MAX_CHARS);
            pool_key[i] = random_text(pool_len[i]);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty key, all-ones key, lookups on a missing key
        send_request(OP_INSERT, '0, '1);
        send_request(OP_SEARCH, '0, '0);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_SEARCH, '1, '1);
        send_request(OP_MODIFY, '1, 64'h0123_4567_89AB_CDEF);
        send_request(OP_SEARCH, '1, '0);
        send_request(OP_DELETE, '1, '1);
        send_request(OP_SEARCH, '1, '0);
        send_request(OP_MODIFY, '1, '1);
        send_request(OP_DELETE, '1, '0);
        // junk after the terminator is dropped; collides with the empty key
        send_request(OP_INSERT, 64'hDEAD_BEEF_C0FF_0041, 64'hFEDC_BA98_7654_3210);
        send_request(OP_SEARCH, 64'h0000_0000_0000_0041, '0);
        // duplicates of the empty key fill the table
        repeat (11) send_request(OP_INSERT, '0, {$urandom, $urandom});
        send_request(OP_INSERT, 64'h0000_0000_0000_0041, '1);
        send_request(OP_DELETE, 64'hFFFF_FFFF_FFFF_FF00, '0);
        send_request(OP_SEARCH, '0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_gap_pct = 49; rsp_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  rsp_stall_pct = 49; end
                default: begin send_gap_pct = 11; rsp_stall_pct = 11; end
            endcase
            repeat (PHASE_ITEMS) random_request();
        end
        s_tvalid <= 1'b0;

        while (expected_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_total == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
